// ===== rtl/urt_pkg.sv =====
// Package for the user region table: sizes, operation codes, controller states
// and the command and status bundles between controller and datapath.
// No dependencies.
package urt_pkg;

    localparam int MAX_REGIONS = 16;
    localparam int IDX_W       = $clog2(MAX_REGIONS);
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam int ADDR_W      = 64;
    localparam int ATTR_W      = 8;
    localparam int PAGE_BITS   = 12;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_DATA_W   = 3 * ADDR_W + ATTR_W;
    localparam int OUT_DATA_W  = 2 * ADDR_W + ATTR_W;

    localparam logic [CFG_IDX_W-1:0] CFG_MMAP_BASE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MMAP_LIMIT = 1'd1;

    typedef enum logic [2:0] {
        F_ADD      = 3'd0,
        F_ALLOC    = 3'd1,
        F_SETMAP   = 3'd2,
        F_FIND     = 3'd3,
        F_REMOVE   = 3'd4,
        F_CONTAINS = 3'd5,
        F_CLEAR    = 3'd6,
        F_NONE     = 3'd7
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_CALC,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic prep;
        logic calc;
        logic scan;
        logic shift;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic scan_end;
        logic shift_need;
        logic shift_end;
    } t_sts;

endpackage

// ===== rtl/user_region_table_unit.sv =====
// Top level of the user region table: stream ports, configuration port,
// controller and datapath. Depends on urt_pkg, urt_ctrl and urt_dp.
//
// channel   direction  handshake              payload
// s_axis    in         tvalid/tready          tuser: func; tdata: operation fields
// m_axis    out        tvalid/tready          tuser: status; tdata: result fields
// cfg       in         write enable, no wait  index, 64-bit data
//
// With C used entries the scan of an operation covers up to C entries; a hit at
// entry h stops the scan early, except remove, which shifts the rest down and so
// always walks all C entries. The input is ready again in the cycle the result appears.
// The scan of the register table, one entry a cycle, sets the length of an operation.
// Reset is synchronous, active low; the table needs no clearing pass.
// A result waiting in the output register does not block the next accept, but the
// following result is held until that beat has left.
module user_region_table_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tuser: func[2:0]
    input  logic [2:0]                          i_s_axis_tuser,
    // tdata: start_addr[63:0], length[127:64], phys_addr[191:128], attr_flags[199:192]
    input  logic [urt_pkg::IN_DATA_W-1:0]       i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tuser: status[0]
    output logic [0:0]                          o_m_axis_tuser,
    // tdata: granted_addr[63:0], found_phys[127:64], found_flags[135:128]
    output logic [urt_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [urt_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [urt_pkg::ADDR_W-1:0]          i_cfg_data
);
    import urt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequence the operation
    urt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (sts),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (cmd)
    );

    // table and arithmetic
    urt_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_func     (i_s_axis_tuser),
        .i_data     (i_s_axis_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_sts      (sts),
        .o_status   (o_m_axis_tuser[0]),
        .o_data     (o_m_axis_tdata)
    );

endmodule

// ===== rtl/urt_ctrl.sv =====
// Controller of the user region table: sequences load, address set-up, table
// scan, entry shift and result hand-off. Depends on urt_pkg.
module urt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_ready,
    input  urt_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output urt_pkg::t_cmd o_cmd
);
    import urt_pkg::*;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;

    // State and result-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_ovalid   = r_ovalid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_CALC;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_end) begin
                    n_state = i_sts.shift_need ? S_SHIFT : S_FINISH;
                end
            end
            S_SHIFT: begin
                if (i_sts.shift_end) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.shift = 1'b1;
                end
            end
            S_FINISH: begin
                // hold until the previous beat has left the output register
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_ovalid     = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_ovalid;

endmodule

// ===== rtl/urt_dp.sv =====
// Datapath of the user region table: region store, count, bump pointer,
// configuration registers, scan compare and output register. Depends on urt_pkg.
module urt_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  urt_pkg::t_cmd                         i_cmd,
    input  logic [2:0]                            i_func,
    input  logic [urt_pkg::IN_DATA_W-1:0]         i_data,
    input  logic                                  i_cfg_we,
    input  logic [urt_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [urt_pkg::ADDR_W-1:0]            i_cfg_data,
    output urt_pkg::t_sts                         o_sts,
    output logic                                  o_status,
    output logic [urt_pkg::OUT_DATA_W-1:0]        o_data
);
    import urt_pkg::*;

    localparam logic [ADDR_W-1:0] PAGE_M1 = ADDR_W'((1 << PAGE_BITS) - 1);
    localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_REGIONS);

    // region store
    logic [ADDR_W-1:0] r_rstart [MAX_REGIONS];
    logic [ADDR_W-1:0] r_rend   [MAX_REGIONS];
    logic [ADDR_W-1:0] r_rphys  [MAX_REGIONS];
    logic [ATTR_W-1:0] r_rattr  [MAX_REGIONS];

    logic [CNT_W-1:0]  r_count;
    logic [ADDR_W-1:0] r_nfree;
    logic [ADDR_W-1:0] r_base, r_limit;

    // operation registers
    t_func             r_func;
    logic [ADDR_W-1:0] r_a, r_b, r_phys, r_s, r_e;
    logic [ATTR_W-1:0] r_attr;
    logic              r_zlen, r_pv, r_go, r_hit;
    logic [CNT_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_hidx;
    logic [ADDR_W-1:0] r_fphys;
    logic [ATTR_W-1:0] r_fattr;

    // output register
    logic              r_ostat;
    logic [ADDR_W-1:0] r_ogrant, r_ophys;
    logic [ATTR_W-1:0] r_oattr;

    logic [ADDR_W:0]   rnd_nf, rnd_len, sum_e;
    logic [IDX_W-1:0]  k;
    logic              at_end, cond, found_now, is_fit, success;

    assign rnd_nf  = {1'b0, r_nfree} + {1'b0, PAGE_M1};
    assign rnd_len = {1'b0, r_b} + {1'b0, PAGE_M1};
    assign sum_e   = {1'b0, r_s} + {1'b0, r_b};

    // compare the entry under the scan index
    assign k      = r_idx[IDX_W-1:0];
    assign at_end = (r_idx == r_count);
    assign is_fit = (r_func == F_ADD) || (r_func == F_ALLOC);
    always_comb begin
        case (r_func)
            F_ADD, F_ALLOC: cond = (r_s < r_rend[k]) && (r_e > r_rstart[k]);
            F_SETMAP, F_FIND, F_REMOVE:
                cond = (r_rstart[k] == r_s) && (r_rend[k] == r_e);
            F_CONTAINS: cond = (r_s >= r_rstart[k]) && (r_e <= r_rend[k]);
            default: cond = 1'b0;
        endcase
    end
    assign found_now = i_cmd.scan && r_go && !at_end && cond;

    assign o_sts.scan_end   = !r_go || at_end || found_now;
    assign o_sts.shift_need = (r_func == F_REMOVE) && (r_hit || found_now);
    assign o_sts.shift_end  = at_end;

    // result of the finished operation
    always_comb begin
        case (r_func)
            F_ADD, F_ALLOC:             success = r_go && !r_hit;
            F_SETMAP, F_FIND, F_REMOVE: success = r_go && r_hit;
            F_CONTAINS:                 success = r_zlen || (r_go && r_hit);
            F_CLEAR:                    success = 1'b1;
            default:                    success = 1'b0;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_limit <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MMAP_BASE:  r_base  <= i_cfg_data;
                CFG_MMAP_LIMIT: r_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control state: count, bump pointer, scan index and hit flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_nfree <= '0;
            r_idx   <= '0;
            r_hit   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx <= '0;
                r_hit <= 1'b0;
            end
            if ((i_cmd.scan || i_cmd.shift) && !at_end) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (found_now) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.finish) begin
                if (is_fit && success) begin
                    r_count <= r_count + CNT_W'(1);
                end
                if ((r_func == F_ALLOC) && success) begin
                    r_nfree <= r_e;
                end
                if ((r_func == F_REMOVE) && success) begin
                    r_count <= r_count - CNT_W'(1);
                end
                if (r_func == F_CLEAR) begin
                    r_count <= '0;
                    r_nfree <= r_base;
                end
            end
        end
    end

    // operation payload, set-up and table writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= t_func'(i_func);
            r_a    <= i_data[ADDR_W-1:0];
            r_b    <= i_data[2*ADDR_W-1:ADDR_W];
            r_phys <= i_data[3*ADDR_W-1:2*ADDR_W];
            r_attr <= i_data[IN_DATA_W-1:3*ADDR_W];
            r_zlen <= (i_data[2*ADDR_W-1:ADDR_W] == '0);
        end
        // round start and size for alloc, else take the start as given
        if (i_cmd.prep) begin
            if (r_func == F_ALLOC) begin
                r_s  <= rnd_nf[ADDR_W-1:0] & ~PAGE_M1;
                r_b  <= rnd_len[ADDR_W-1:0] & ~PAGE_M1;
                r_pv <= !r_zlen && !rnd_nf[ADDR_W] && !rnd_len[ADDR_W];
            end else begin
                r_s  <= r_a;
                r_pv <= !r_zlen;
            end
        end
        // form the end and decide whether the scan runs
        if (i_cmd.calc) begin
            r_e <= sum_e[ADDR_W-1:0];
            case (r_func)
                F_ADD: r_go <= r_pv && !sum_e[ADDR_W] && (r_count < MAX_CNT);
                F_ALLOC: r_go <= r_pv && !sum_e[ADDR_W] && (r_count < MAX_CNT)
                                 && (sum_e[ADDR_W-1:0] <= r_limit);
                F_SETMAP, F_FIND, F_REMOVE, F_CONTAINS:
                    r_go <= r_pv && !sum_e[ADDR_W];
                default: r_go <= 1'b0;
            endcase
        end
        if (found_now) begin
            r_hidx  <= k;
            r_fphys <= r_rphys[k];
            r_fattr <= r_rattr[k];
        end
        // move the later entries down one place
        if (i_cmd.shift && !at_end) begin
            r_rstart[k - IDX_W'(1)] <= r_rstart[k];
            r_rend[k - IDX_W'(1)]   <= r_rend[k];
            r_rphys[k - IDX_W'(1)]  <= r_rphys[k];
            r_rattr[k - IDX_W'(1)]  <= r_rattr[k];
        end
        if (i_cmd.finish) begin
            if (is_fit && success) begin
                r_rstart[r_count[IDX_W-1:0]] <= r_s;
                r_rend[r_count[IDX_W-1:0]]   <= r_e;
                r_rphys[r_count[IDX_W-1:0]]  <= '0;
                r_rattr[r_count[IDX_W-1:0]]  <= '0;
            end
            if ((r_func == F_SETMAP) && success) begin
                r_rphys[r_hidx] <= r_phys;
                r_rattr[r_hidx] <= r_attr;
            end
            r_ostat  <= !success;
            r_ogrant <= ((r_func == F_ALLOC) && success) ? r_s : '0;
            r_ophys  <= (((r_func == F_FIND) || (r_func == F_REMOVE)) && success)
                        ? r_fphys : '0;
            r_oattr  <= (((r_func == F_FIND) || (r_func == F_REMOVE)) && success)
                        ? r_fattr : '0;
        end
    end

    assign o_status = r_ostat;
    assign o_data   = {r_oattr, r_ophys, r_ogrant};

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT) else $error("region count beyond table size");
    a_shift_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.shift && !at_end) |-> (r_idx != '0) && r_hit)
        else $error("shift without a matched entry");
    a_fit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && is_fit && success) |-> (r_count < MAX_CNT))
        else $error("append on a full table");

endmodule
